FILE: hw/rtl/brlp_pkg.sv
package brlp_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_STAMP   = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_INFO    = 3'd2;
  localparam logic [2:0] PH_IDFIRST = 3'd3;
  localparam logic [2:0] PH_IDREST  = 3'd4;
  localparam logic [2:0] PH_DATA    = 3'd5;
  localparam logic [2:0] PH_CODE    = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;

  // Bus codes.
  localparam logic [1:0] BUSCODE_CAN1  = 2'd0;
  localparam logic [1:0] BUSCODE_CAN2  = 2'd1;
  localparam logic [1:0] BUSCODE_LIN1  = 2'd2;
  localparam logic [1:0] BUSCODE_UNSUP = 2'd3;

  // Bus-info decode values under the bus mask.
  localparam logic [7:0] INFO_BUS_MASK = 8'h78;
  localparam logic [7:0] INFO_CAN1     = 8'h10;
  localparam logic [7:0] INFO_CAN2     = 8'h18;
  localparam logic [7:0] INFO_LIN1     = 8'h30;
  localparam int unsigned INFO_TX_BIT  = 1;
  localparam int unsigned ID_EXT_BIT   = 7;

  // Record overhead counted by the length byte.
  localparam logic [7:0] OVERHEAD_STD = 8'd4;
  localparam logic [7:0] OVERHEAD_EXT = 8'd6;

  // Width of the packed output payload, rounded up to whole bytes.
  localparam int unsigned TDATA_W = 88;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] frame_id;
    logic        extended_id;
    logic [1:0]  bus_code;
    logic        is_transmit;
    logic [31:0] time_stamp;
    logic [7:0]  data_value;
    logic [7:0]  data_count;
    logic        length_error;
    logic        last;
  } res_t;

  // Result handed from the parser to the output buffer.
  typedef struct packed {
    logic push;
    res_t res;
  } push_t;

  function automatic logic [1:0] bus_of(input logic [7:0] info);
    logic [1:0] code;
    case (info & INFO_BUS_MASK)
      INFO_CAN1: code = BUSCODE_CAN1;
      INFO_CAN2: code = BUSCODE_CAN2;
      INFO_LIN1: code = BUSCODE_LIN1;
      default:   code = BUSCODE_UNSUP;
    endcase
    return code;
  endfunction

endpackage

FILE: hw/rtl/brlp_parse.sv
module brlp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 space,
  output brlp_pkg::push_t      out
);
  import brlp_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;

  logic [2:0]  phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] stamp_accum, stamp_accum_next;
  logic [7:0]  length_held, length_held_next;
  logic [7:0]  info_held, info_held_next;
  logic [31:0] id_accum, id_accum_next;
  logic [7:0]  data_left, data_left_next;
  logic        ext_flag, ext_flag_next;

  logic        hdr;
  logic [7:0]  overhead;
  logic        short_len;
  logic [7:0]  count;
  logic [1:0]  bi_inc;
  logic [4:0]  id_shift;

  // The input register holds one byte; it moves on when the output buffer has room.
  assign advance  = s1_valid && space;
  assign in_ready = !s1_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  // Header quantities, taken from the identifier as it completes.
  assign overhead  = ext_flag ? OVERHEAD_EXT : OVERHEAD_STD;
  assign short_len = length_held < overhead;
  assign count     = short_len ? 8'd0 : length_held - overhead;
  assign bi_inc    = byte_index + 2'd1;

  always_comb begin
    case (byte_index)
      2'd1:    id_shift = 5'd8;
      2'd2:    id_shift = 5'd0;
      default: id_shift = 5'd16;
    endcase
  end

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    stamp_accum_next = stamp_accum;
    length_held_next = length_held;
    info_held_next   = info_held;
    id_accum_next    = id_accum;
    data_left_next   = data_left;
    ext_flag_next    = ext_flag;
    hdr              = 1'b0;
    out              = '0;

    case (phase)
      PH_LEN: begin
        length_held_next = s1_byte;
        phase_next       = PH_INFO;
      end
      PH_INFO: begin
        info_held_next = s1_byte;
        phase_next     = PH_IDFIRST;
      end
      PH_IDFIRST: begin
        ext_flag_next   = s1_byte[ID_EXT_BIT];
        id_accum_next   = s1_byte[ID_EXT_BIT] ? {s1_byte, 24'd0} : {16'd0, s1_byte, 8'd0};
        byte_index_next = 2'd0;
        phase_next      = PH_IDREST;
      end
      PH_IDREST: begin
        if (!ext_flag) begin
          id_accum_next = id_accum | {24'd0, s1_byte};
          hdr           = 1'b1;
        end else begin
          id_accum_next   = id_accum | ({24'd0, s1_byte} << id_shift);
          byte_index_next = bi_inc;
          if (bi_inc == 2'd3) begin
            byte_index_next = 2'd0;
            hdr             = 1'b1;
          end
        end
      end
      PH_DATA: begin
        out.push           = 1'b1;
        out.res.kind       = KIND_DATA;
        out.res.data_value = s1_byte;
        data_left_next     = data_left - 8'd1;
        if (data_left_next == 8'd0) begin
          phase_next = PH_CODE;
        end
      end
      PH_CODE: begin
        out.push           = 1'b1;
        out.res.kind       = KIND_TRAILER;
        out.res.data_value = s1_byte;
        out.res.last       = 1'b1;
        phase_next         = PH_STAMP;
        byte_index_next    = 2'd0;
      end
      default: begin
        stamp_accum_next = {stamp_accum[23:0], s1_byte};
        byte_index_next  = bi_inc;
        phase_next       = (bi_inc == 2'd0) ? PH_LEN : PH_STAMP;
      end
    endcase

    // A completed identifier produces the header.
    if (hdr) begin
      out.push             = 1'b1;
      out.res.kind         = KIND_HEADER;
      out.res.frame_id     = id_accum_next;
      out.res.extended_id  = ext_flag;
      out.res.bus_code     = bus_of(info_held);
      out.res.is_transmit  = info_held[INFO_TX_BIT];
      out.res.time_stamp   = stamp_accum;
      out.res.data_count   = count;
      out.res.length_error = short_len;
      data_left_next       = count;
      phase_next           = (count != 8'd0) ? PH_DATA : PH_CODE;
    end

    out.push = out.push && advance;
  end

  // Record state advances once per byte taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STAMP;
      byte_index  <= 2'd0;
      stamp_accum <= '0;
      length_held <= '0;
      info_held   <= '0;
      id_accum    <= '0;
      data_left   <= '0;
      ext_flag    <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      stamp_accum <= stamp_accum_next;
      length_held <= length_held_next;
      info_held   <= info_held_next;
      id_accum    <= id_accum_next;
      data_left   <= data_left_next;
      ext_flag    <= ext_flag_next;
    end
  end

  // A header is only produced as the identifier completes.
  a_hdr_phase: assert property (@(posedge clk) disable iff (rst)
    out.push && out.res.kind == KIND_HEADER |-> phase == PH_IDREST)
    else $error("header result outside identifier phase");

  // After a trailer the parser waits for the next timestamp.
  a_trailer_restart: assert property (@(posedge clk) disable iff (rst)
    out.push && out.res.last |=> phase == PH_STAMP && byte_index == 2'd0)
    else $error("parser did not restart after trailer");

  // A result is only produced when the output buffer has room.
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    out.push |-> space)
    else $error("result produced without buffer space");

  // Data phase always has bytes left to deliver.
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> data_left != 8'd0)
    else $error("data phase with no bytes left");

endmodule

FILE: hw/rtl/brlp_ofifo.sv
module brlp_ofifo (
  input  logic             clk,
  input  logic             rst,
  input  brlp_pkg::push_t  in,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output brlp_pkg::res_t   out_res
);
  import brlp_pkg::*;

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  // Space depends only on registered state, so the two sides stay decoupled.
  assign space     = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in.push) begin
      mem[wr_ptr] <= in.res;
    end
  end

  // Pointers and fill count of the two-entry result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, in.push} - {1'b0, pop};
    end
  end

  // The fill count never goes past the buffer depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer overflow");

endmodule

FILE: hw/rtl/bus_log_record_parser_top.sv
// Bus-capture log record parser. Raw log bytes enter on s_t* one per transaction and records
// leave on m_t*: a header (tuser 0) once the identifier is complete, one data result
// (tuser 1) per data byte, then a trailer (tuser 2) carrying the completion code with tlast
// set. Bytes of the timestamp, length and bus info produce no result, nor does an identifier
// byte other than the last. One byte is accepted every clock cycle unless input is stalled;
// each byte passes an input register, combinational parsing logic and a two-entry output
// buffer. Backpressure on m_tready stalls input only once the output buffer is full.
module bus_log_record_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // in_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // frame_id[31:0], extended_id[32], bus_code[34:33], is_transmit[35],
  // time_stamp[67:36], data_value[75:68], data_count[83:76], length_error[84], zero pad
  output logic [brlp_pkg::TDATA_W-1:0]    m_tdata,
  output logic [1:0]                      m_tuser,  // kind
  output logic                            m_tlast   // last
);
  import brlp_pkg::*;

  push_t push;
  logic  space;
  res_t  res;

  brlp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .space    (space),
    .out      (push)
  );

  brlp_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .in        (push),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack the result fields onto the stream payload.
  assign m_tdata = {3'd0, res.length_error, res.data_count, res.data_value, res.time_stamp,
                    res.is_transmit, res.bus_code, res.extended_id, res.frame_id};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
